/* design/olist_pkg.sv */
package olist_pkg;

  // Default geometry of the list.
  localparam int unsigned DefDepth    = 128;
  localparam int unsigned DefKeyWidth = 32;

  // Widths of the transfer fields.
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyFldW = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SlotW   = 7;

  // Operation codes.
  localparam logic [OpW-1:0] OpAppend  = 2'd0;
  localparam logic [OpW-1:0] OpPrepend = 2'd1;
  localparam logic [OpW-1:0] OpInsert  = 2'd2;
  localparam logic [OpW-1:0] OpRemove  = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] StatDone     = 2'd0;
  localparam logic [StatW-1:0] StatRejected = 2'd1;
  localparam logic [StatW-1:0] StatNotFound = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [KeyFldW-1:0] key;
    logic [PosW-1:0]    position;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [CountW-1:0] entry_count;
    logic [SlotW-1:0]  slot_index;
  } rsp_t;

  // Per-cell control: what the cell takes at the next clock edge.
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctrl_t;

endpackage

/* design/olist_cell.sv */
module olist_cell #(
  parameter int unsigned KeyW = olist_pkg::DefKeyWidth
) (
  input  logic                   clk_i,
  input  logic [KeyW-1:0]        key_i,
  input  logic [KeyW-1:0]        left_i,
  input  logic [KeyW-1:0]        right_i,
  input  olist_pkg::cell_ctrl_t  ctrl_i,
  output logic [KeyW-1:0]        data_o,
  output logic                   match_o
);
  import olist_pkg::*;

  logic [KeyW-1:0] data_q, data_d;

  // Next entry: a new key, the lower neighbor (shift up), the upper neighbor
  // (shift down), or the current entry.
  always_comb begin
    priority if (ctrl_i.load) begin
      data_d = key_i;
    end else if (ctrl_i.from_left) begin
      data_d = left_i;
    end else if (ctrl_i.from_right) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Local key compare for remove.
  assign match_o = (data_q == key_i);
  assign data_o  = data_q;

endmodule

/* design/olist_prefix.sv */
module olist_prefix #(
  parameter int unsigned DEPTH = olist_pkg::DefDepth
) (
  input  logic [DEPTH-1:0]         match_i,
  output logic [DEPTH-1:0]         incl_o,
  output logic                     found_o,
  output logic [$clog2(DEPTH)-1:0] first_o
);
  import olist_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned Lv   = $clog2(DEPTH);

  logic [DEPTH-1:0] lvl [Lv+1];
  logic [DEPTH-1:0] first_hot;
  logic [IdxW-1:0]  first_idx;

  // Log-depth prefix OR: incl_o[i] is set when some cell at or below i matches.
  always_comb begin
    lvl[0] = match_i;
    for (int k = 0; k < Lv; k++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << k)) begin
          lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
        end else begin
          lvl[k+1][i] = lvl[k][i];
        end
      end
    end
  end

  // One-hot lowest match and its index, gathered by an OR reduction.
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        first_hot[i] = lvl[Lv][i];
      end else begin
        first_hot[i] = lvl[Lv][i] & ~lvl[Lv][i-1];
      end
      first_idx = first_idx | (first_hot[i] ? IdxW'(i) : '0);
    end
  end

  assign incl_o  = lvl[Lv];
  assign found_o = lvl[Lv][DEPTH-1];
  assign first_o = first_idx;

endmodule

/* design/ordered_list_insert_remove_unit.sv */
// Ordered key list held in a row of cells, one entry per cell. Append, prepend
// and insert are decided and applied in the cycle the command transfer happens;
// the result strobes on done_o in the next cycle and busy_o stays low, so one
// such command is taken every cycle while no remove is under way. For a remove,
// every cell first compares its entry with the key, then a prefix OR over the
// registered match bits finds the lowest match, then the cells above it shift
// down by one; busy_o stays high until the shift is applied and the result
// strobes as it falls. done_o is high for exactly one cycle per command and
// the result cannot be held off, so the receiver must take it in that cycle.
module ordered_list_insert_remove_unit #(
  parameter int unsigned DEPTH     = olist_pkg::DefDepth,
  parameter int unsigned KEY_WIDTH = olist_pkg::DefKeyWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  olist_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output olist_pkg::rsp_t rsp_o
);
  import olist_pkg::*;

  localparam int unsigned KeyW = (KEY_WIDTH < KeyFldW) ? KEY_WIDTH : KeyFldW;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned AtW  = CntW + PosW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StApply
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  rsp_t            rsp_q;

  logic [DEPTH-1:0] match_q;
  logic [DEPTH-1:0] incl_q;
  logic             found_q;
  logic [IdxW-1:0]  first_q;

  logic [DEPTH-1:0] incl_w;
  logic             found_w;
  logic [IdxW-1:0]  first_w;

  logic [KeyW-1:0]  key_w;
  logic             accept_w;
  logic             ins_ok_w;
  logic             ins_rej_w;
  logic [AtW-1:0]   at_w;
  logic [AtW-1:0]   cnt_at_w;

  logic [KeyW-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] match_d;
  cell_ctrl_t       cell_ctrl [DEPTH];

  assign key_w    = req_i.key[KeyW-1:0];
  assign accept_w = start_i && (state_q == StIdle);

  // Insert position and admission check.
  assign cnt_at_w = {{PosW{1'b0}}, cnt_q};
  always_comb begin
    unique case (req_i.operation)
      OpAppend:  at_w = cnt_at_w;
      OpPrepend: at_w = '0;
      default:   at_w = {{CntW{1'b0}}, req_i.position};
    endcase
  end
  assign ins_rej_w = (cnt_q == CntW'(DEPTH)) || (at_w > cnt_at_w);
  assign ins_ok_w  = accept_w && (req_i.operation != OpRemove) && !ins_rej_w;

  // Row of cells; each takes from its neighbors as the control says.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [AtW-1:0]  IdAt  = AtW'(i);
    localparam logic [CntW-1:0] IdCnt = CntW'(i);
    localparam logic [CntW-1:0] IdNx  = CntW'(i + 1);

    logic [KeyW-1:0] left_w;
    logic [KeyW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cell_data[i];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    assign cell_ctrl[i].load       = ins_ok_w && (IdAt == at_w);
    assign cell_ctrl[i].from_left  = ins_ok_w && (i != 0) && (IdAt > at_w)
                                     && (IdAt <= cnt_at_w);
    assign cell_ctrl[i].from_right = (state_q == StApply) && found_q && incl_q[i]
                                     && (IdNx < cnt_q);
    assign match_d[i] = cell_match[i] && (IdCnt < cnt_q);

    olist_cell #(
      .KeyW(KeyW)
    ) u_cell (
      .clk_i  (clk_i),
      .key_i  (key_w),
      .left_i (left_w),
      .right_i(right_w),
      .ctrl_i (cell_ctrl[i]),
      .data_o (cell_data[i]),
      .match_o(cell_match[i])
    );
  end

  // Lowest-match search over the registered match bits.
  olist_prefix #(
    .DEPTH(DEPTH)
  ) u_prefix (
    .match_i(match_q),
    .incl_o (incl_w),
    .found_o(found_w),
    .first_o(first_w)
  );

  // Search pipeline registers.
  always_ff @(posedge clk_i) begin
    if (accept_w && (req_i.operation == OpRemove)) begin
      match_q <= match_d;
    end
    if (state_q == StScan) begin
      incl_q  <= incl_w;
      found_q <= found_w;
      first_q <= first_w;
    end
  end

  // Result formatting.
  logic [CntW-1:0]       cnt_ins_w;
  logic [CntW-1:0]       cnt_rem_w;
  logic [CntW+CountW-1:0] cnt_ins_ext;
  logic [CntW+CountW-1:0] cnt_rem_ext;
  logic [AtW+SlotW-1:0]  at_ext;
  logic [IdxW+SlotW-1:0] first_ext;

  assign cnt_ins_w   = ins_ok_w ? cnt_q + CntW'(1) : cnt_q;
  assign cnt_rem_w   = found_q ? cnt_q - CntW'(1) : cnt_q;
  assign cnt_ins_ext = {{CountW{1'b0}}, cnt_ins_w};
  assign cnt_rem_ext = {{CountW{1'b0}}, cnt_rem_w};
  assign at_ext      = {{SlotW{1'b0}}, at_w};
  assign first_ext   = {{SlotW{1'b0}}, first_q};

  // Control state, count and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept_w) begin
            if (req_i.operation == OpRemove) begin
              state_q <= StScan;
            end else begin
              cnt_q             <= cnt_ins_w;
              done_q            <= 1'b1;
              rsp_q.status      <= ins_rej_w ? StatRejected : StatDone;
              rsp_q.entry_count <= cnt_ins_ext[CountW-1:0];
              rsp_q.slot_index  <= ins_rej_w ? '0 : at_ext[SlotW-1:0];
            end
          end
        end
        StScan: begin
          state_q <= StApply;
        end
        StApply: begin
          state_q           <= StIdle;
          cnt_q             <= cnt_rem_w;
          done_q            <= 1'b1;
          rsp_q.status      <= found_q ? StatDone : StatNotFound;
          rsp_q.entry_count <= cnt_rem_ext[CountW-1:0];
          rsp_q.slot_index  <= found_q ? first_ext[SlotW-1:0] : '0;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
